FILE: src/fud_pkg.sv
// Shared types, character codes and helpers for the form body decoder.
package fud_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_EQ    = 8'h3D;
  localparam logic [7:0] CHR_AMP   = 8'h26;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_KEY_END   = 2'd1,
    KIND_VALUE_END = 2'd2,
    KIND_EMPTY_END = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_PCT   = 2'd1,
    HOLD_DIGIT = 2'd2
  } hold_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      out_kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic       body_end;
  } out_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0]         res;
    logic [$clog2(MaxRes+1)-1:0] cnt;
    logic                      body_end;
  } group_t;

  // 0..15 for a hex digit, 16 otherwise
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    return v;
  endfunction

endpackage

FILE: src/fud_decode.sv
// Decode stage: percent/plus decoding, segment split and hold state.
module fud_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  fud_pkg::in_item_t item_i,
  output fud_pkg::group_t   group_o
);
  import fud_pkg::*;

  hold_e      hold_q, hold_d;
  logic [7:0] digit_q, digit_d;
  logic       seg_q, seg_d;

  logic [7:0] c;
  logic       last;
  logic [4:0] hv, hd;
  logic       fresh_hold;
  logic [7:0] fresh_byte;
  logic [7:0] cand [3];
  logic [1:0] n_cand;
  logic       seg;

  assign c          = item_i.in_byte;
  assign last       = item_i.last_byte;
  assign hv         = hex_val(c);
  assign hd         = hex_val(digit_q);
  assign fresh_hold = (c == CHR_PCT) && !last;
  assign fresh_byte = (c == CHR_PLUS) ? CHR_SPACE : c;

  always_comb begin
    hold_d  = HOLD_NONE;
    digit_d = digit_q;
    n_cand  = 2'd0;
    cand[0] = CHR_PCT;
    cand[1] = fresh_byte;
    cand[2] = fresh_byte;
    case (hold_q)
      HOLD_PCT: begin
        if (!hv[4] && !last) begin
          hold_d  = HOLD_DIGIT;
          digit_d = c;
        end else if (fresh_hold) begin
          hold_d = HOLD_PCT;
          n_cand = 2'd1;
        end else begin
          n_cand = 2'd2;
        end
      end
      HOLD_DIGIT: begin
        digit_d = '0;
        if (!hv[4]) begin
          cand[0] = {hd[3:0], hv[3:0]};
          n_cand  = 2'd1;
        end else begin
          cand[1] = digit_q;
          if (fresh_hold) begin
            hold_d = HOLD_PCT;
            n_cand = 2'd2;
          end else begin
            n_cand = 2'd3;
          end
        end
      end
      default: begin
        cand[0] = fresh_byte;
        if (fresh_hold) hold_d = HOLD_PCT;
        else n_cand = 2'd1;
      end
    endcase
    if (last) digit_d = '0;
  end

  always_comb begin
    group_o = '0;
    seg     = seg_q;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_cand) begin
        if (cand[i] == CHR_EQ) begin
          group_o.res[i].kind = KIND_KEY_END;
          seg = 1'b0;
        end else if (cand[i] == CHR_AMP) begin
          group_o.res[i].kind = KIND_VALUE_END;
          seg = 1'b0;
        end else begin
          group_o.res[i].kind = KIND_BYTE;
          group_o.res[i].data = cand[i];
          seg = 1'b1;
        end
      end
    end
    group_o.cnt = {1'b0, n_cand};
    seg_d       = seg;
    if (last) begin
      group_o.res[n_cand].kind = seg ? KIND_VALUE_END : KIND_EMPTY_END;
      group_o.cnt              = {1'b0, n_cand} + 3'd1;
      group_o.body_end         = 1'b1;
      seg_d                    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= HOLD_NONE;
      digit_q <= '0;
      seg_q   <= 1'b0;
    end else if (fire_i) begin
      hold_q  <= hold_d;
      digit_q <= digit_d;
      seg_q   <= seg_d;
    end
  end

endmodule

FILE: src/fud_outbuf.sv
// Result buffer: holds one item's results and hands them out one per cycle while out_stall_i is low.
module fud_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  fud_pkg::group_t     group_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fud_pkg::out_item_t  out_item_o
);
  import fud_pkg::*;

  group_t     group_q;
  logic [2:0] cnt_q;
  logic [1:0] idx_q;
  logic       is_final;
  logic       out_fire;

  assign out_valid_o = (cnt_q != 3'd0);
  assign is_final    = ({1'b0, idx_q} + 3'd1) == cnt_q;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign ready_o     = !out_valid_o || (out_fire && is_final);

  assign out_item_o.out_kind = group_q.res[idx_q].kind;
  assign out_item_o.out_byte = group_q.res[idx_q].data;
  assign out_item_o.run_last = is_final;
  assign out_item_o.body_end = is_final && group_q.body_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= group_i.cnt;
      idx_q <= '0;
    end else if (out_fire) begin
      if (is_final) cnt_q <= '0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) group_q <= group_i;
  end

endmodule

FILE: src/form_urlencoded_decoder.sv
// Top level of the form body decoder.
// Decodes an application/x-www-form-urlencoded body one byte per item: "%XX" (either case)
// becomes one byte, '+' a space, and decoded '=' and '&' close key and value segments; at
// the last byte a value-end or empty-tail marker follows. Each input item yields zero to
// four results, delivered one per cycle from a result buffer with run_last on the final
// one. A new item is taken in the same cycle the buffer hands out its final result, so
// the block sustains one item per cycle while items give at most one result and out_stall_i
// stays low; an item with several results keeps the output busy until its run_last one is taken.
module form_urlencoded_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fud_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fud_pkg::out_item_t out_item_o
);
  import fud_pkg::*;

  group_t group;
  logic   ready;
  logic   in_fire;

  assign in_stall_o = !ready;
  assign in_fire    = in_valid_i && ready;

  fud_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .item_i  (in_item_i),
    .group_o (group)
  );

  fud_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .group_i     (group),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.body_end |-> out_item_o.run_last)
    else $error("body end not on last result of item");

  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.body_end |->
      (out_item_o.out_kind == KIND_VALUE_END || out_item_o.out_kind == KIND_EMPTY_END))
    else $error("body end on wrong result kind");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_kind != KIND_BYTE |-> out_item_o.out_byte == 8'd0)
    else $error("marker result carries a byte");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty buffer");

endmodule

FILE: dv/form_urlencoded_decoder_tb.sv
// Self-checking testbench for the form body decoder: directed and random bodies, scoreboard.
`timescale 1ns / 100ps

module form_urlencoded_decoder_tb;
  import fud_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 450;
  localparam int unsigned LongHoldOff   = 300;
  localparam int unsigned DrainCycles   = 20;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  form_urlencoded_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  in_item_t    body_bytes[$];
  out_item_t   decoded_q[$];
  out_item_t   step_q[$];
  logic [7:0]  text_q[$];

  hold_e       hold_st    = HOLD_NONE;
  logic [7:0]  held_ch    = '0;
  logic        seg_open   = 1'b0;

  int unsigned n_errors   = 0;
  int unsigned items_in   = 0;
  int unsigned cyc        = 0;
  int unsigned idle_cyc   = 0;
  int unsigned tx_gap     = 0;
  int unsigned rx_gap     = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  logic        in_accepted = 1'b0;
  logic        got_in;
  logic        got_out;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- decoder
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return 5'd16;
  endfunction

  task automatic push_res(kind_e k, logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_kind = k;
    r.out_byte = (k == KIND_BYTE) ? b : 8'h00;
    step_q.push_back(r);
  endtask

  task automatic split_char(logic [7:0] b);
    if (b == CHR_EQ) begin
      push_res(KIND_KEY_END, 8'h00);
      seg_open = 1'b0;
    end else if (b == CHR_AMP) begin
      push_res(KIND_VALUE_END, 8'h00);
      seg_open = 1'b0;
    end else begin
      push_res(KIND_BYTE, b);
      seg_open = 1'b1;
    end
  endtask

  task automatic fresh_char(logic [7:0] b, logic fin);
    if (b == CHR_PCT && !fin) hold_st = HOLD_PCT;
    else if (b == CHR_PLUS) split_char(CHR_SPACE);
    else split_char(b);
  endtask

  task automatic decode_item(in_item_t it);
    logic [7:0] c;
    logic       fin;
    logic [4:0] lo;
    logic [4:0] hi;
    out_item_t  r;
    c   = it.in_byte;
    fin = it.last_byte;
    lo  = nibble_of(c);
    step_q.delete();
    case (hold_st)
      HOLD_PCT: begin
        hold_st = HOLD_NONE;
        if (lo < 5'd16 && !fin) begin
          held_ch = c;
          hold_st = HOLD_DIGIT;
        end else begin
          split_char(CHR_PCT);
          fresh_char(c, fin);
        end
      end
      HOLD_DIGIT: begin
        hold_st = HOLD_NONE;
        hi = nibble_of(held_ch);
        if (lo < 5'd16) begin
          split_char({hi[3:0], lo[3:0]});
        end else begin
          split_char(CHR_PCT);
          split_char(held_ch);
          fresh_char(c, fin);
        end
        held_ch = '0;
      end
      default: begin
        hold_st = HOLD_NONE;
        fresh_char(c, fin);
      end
    endcase
    if (fin) begin
      if (seg_open) push_res(KIND_VALUE_END, 8'h00);
      else push_res(KIND_EMPTY_END, 8'h00);
      r = step_q.pop_back();
      r.body_end = 1'b1;
      step_q.push_back(r);
      hold_st  = HOLD_NONE;
      held_ch  = '0;
      seg_open = 1'b0;
    end
    if (step_q.size() != 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      n_errors++;
    end
  endtask

  task automatic check_result(out_item_t act);
    out_item_t exp;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected item, expected none, actual kind %0d byte %0h",
               $time, act.out_kind, act.out_byte);
      n_errors++;
    end else begin
      exp = decoded_q.pop_front();
      check_field("out_kind", exp.out_kind, act.out_kind);
      check_field("out_byte", exp.out_byte, act.out_byte);
      check_field("run_last", exp.run_last, act.run_last);
      check_field("body_end", exp.body_end, act.body_end);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    if ($urandom_range(0, 1) != 0) return "A" + n - 8'd10;
    return "a" + n - 8'd10;
  endfunction

  task automatic push_byte(logic [7:0] b, logic fin);
    in_item_t it;
    it.in_byte   = b;
    it.last_byte = fin;
    body_bytes.push_back(it);
  endtask

  task automatic push_str(string s, logic fin);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic add_char();
    string       plain;
    string       junk;
    int unsigned r;
    logic [7:0]  b;
    plain = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.*";
    junk  = "gGxZ %+=&~";
    r = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (r < 55) begin
      text_q.push_back(plain[$urandom_range(0, plain.len() - 1)]);
    end else if (r < 65) begin
      text_q.push_back(CHR_PLUS);
    end else if (r < 85) begin
      text_q.push_back(CHR_PCT);
      text_q.push_back(hex_char(b[7:4]));
      text_q.push_back(hex_char(b[3:0]));
    end else if (r < 93) begin
      text_q.push_back(CHR_PCT);
      if ($urandom_range(0, 1) != 0) text_q.push_back(hex_char(b[3:0]));
      text_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
    end else begin
      text_q.push_back(b);
    end
  endtask

  task automatic add_body();
    int unsigned n_pairs;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_pairs = $urandom_range(1, 3);
      for (int p = 0; p < n_pairs; p++) begin
        if (p != 0) text_q.push_back(CHR_AMP);
        repeat ($urandom_range(0, 5)) add_char();
        if ($urandom_range(0, 9) != 0) text_q.push_back(CHR_EQ);
        repeat ($urandom_range(0, 6)) add_char();
      end
      if ($urandom_range(0, 7) == 0) text_q.push_back(CHR_AMP);
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
    foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin
    in_item_t it;
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (body_bytes.size() != 0) begin
          it = body_bytes.pop_front();
          in_item_i  <= it;
          in_valid_i <= 1'b1;
          tx_gap     <= (cyc[7:6] == 2'b01) ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && items_in >= 120) begin
        hold_done   <= 1'b1;
        hold_left   <= LongHoldOff;
        out_stall_i <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap      <= rx_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        rx_gap      <= (cyc[8:7] == 2'b10) ? 0 : pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      got_in  = in_valid_i && !in_stall_o;
      got_out = out_valid_o && !out_stall_i;
      in_accepted <= got_in;
      if (got_in) begin
        decode_item(in_item_i);
        items_in++;
      end
      if (got_out) check_result(out_item_o);
      if (got_in || got_out) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cyc);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int unsigned n_random;
    push_byte(8'h00, 1'b0);
    push_str("%fF", 1'b0);
    push_str("=", 1'b0);
    push_str("+", 1'b0);
    push_str("%3D", 1'b0);
    push_str("%26", 1'b0);
    push_str("%g", 1'b0);
    push_str("%a%", 1'b0);
    push_str("4", 1'b1);
    push_str("%", 1'b1);
    push_str("%B&", 1'b1);
    push_str("=", 1'b1);
    push_str("%e9", 1'b1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender pauses until the directed bodies have fully drained
    do @(posedge clk_i);
    while (body_bytes.size() != 0 || in_valid_i || decoded_q.size() != 0);

    n_random = 0;
    while (n_random < RandomItems) begin
      add_body();
      n_random += text_q.size();
    end

    do @(posedge clk_i);
    while (body_bytes.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: form_urlencoded_decoder.f
src/fud_pkg.sv
src/fud_decode.sv
src/fud_outbuf.sv
src/form_urlencoded_decoder.sv
dv/form_urlencoded_decoder_tb.sv
